FILE: hw/rtl/square_matrix_multiply_unit_assert.svh
// Assertion helpers for the matrix multiply unit.
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned IDX_W    = 2;
    localparam int unsigned DIM_W    = 3;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [DIM_W-1:0] MIN_DIM       = 3'd3;
    localparam logic [DIM_W-1:0] DIM_RESET     = 3'd4;
    localparam logic [APB_AW-3:0] REG_DIMENSION = 1'b0;

    // multiply register plus accumulate register behind the read stage
    localparam logic [1:0] PIPE_DRAIN = 2'd1;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_EMIT
    } smm_state_t;

    typedef struct packed {
        logic             store;
        logic             mac_issue;
        logic             mac_first;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] term;
        logic             emit;
        logic             last;
    } smm_cmd_t;

    typedef struct packed {
        logic out_full;
    } smm_stat_t;

endpackage

FILE: hw/rtl/smm_chan_if.sv
`timescale 1ns / 1ps

interface smm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] element_value;
    logic               target_matrix;
    logic [1:0]         column_index;
    logic [1:0]         row_index;
    logic               compute_now;

    modport source (
        output valid, element_value, target_matrix, column_index, row_index, compute_now,
        input  ready
    );
    modport sink (
        input  valid, element_value, target_matrix, column_index, row_index, compute_now,
        output ready
    );
endinterface

interface smm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] product_value;
    logic [1:0]         out_column;
    logic [1:0]         out_row;
    logic               saturated;
    logic               last_result;

    modport source (
        output valid, product_value, out_column, out_row, saturated, last_result,
        input  ready
    );
    modport sink (
        input  valid, product_value, out_column, out_row, saturated, last_result,
        output ready
    );
endinterface

FILE: hw/rtl/smm_ctrl.sv
`timescale 1ns / 1ps

module smm_ctrl
    import smm_pkg::*;
#(
    parameter int unsigned MAX_DIM = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] dimension,
    input  logic             in_valid,
    input  logic             in_compute,
    output logic             in_ready,
    input  smm_stat_t        stat,
    output smm_cmd_t         cmd
);

    smm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] r_reg, r_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] lim_reg, lim_next;
    logic [1:0]       drain_reg, drain_next;
    logic [DIM_W-1:0] act_dim;
    logic             accept;
    logic             start;
    logic             emit_ok;
    logic             last_term;
    logic             last_row;
    logic             last_col;

    always_comb
    begin
        if (dimension < MIN_DIM)
        begin
            act_dim = MIN_DIM;
        end
        else if (dimension > DIM_W'(MAX_DIM))
        begin
            act_dim = DIM_W'(MAX_DIM);
        end
        else
        begin
            act_dim = dimension;
        end
    end

    assign accept    = (state_reg == S_IDLE) && in_valid;
    assign start     = accept && in_compute;
    assign emit_ok   = !stat.out_full;
    assign last_term = (i_reg == lim_reg);
    assign last_row  = (r_reg == lim_reg);
    assign last_col  = (c_reg == lim_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (last_term)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = (last_row && last_col) ? S_IDLE : S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.store     = 1'b0;
        cmd.mac_issue = 1'b0;
        cmd.mac_first = 1'b0;
        cmd.col       = c_reg;
        cmd.row       = r_reg;
        cmd.term      = i_reg;
        cmd.emit      = 1'b0;
        cmd.last      = last_row && last_col;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.store = in_valid;
            end
            S_ISSUE:
            begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (i_reg == '0);
            end
            S_DRAIN:
            begin
                cmd.mac_issue = 1'b0;
            end
            S_EMIT:
            begin
                cmd.emit = emit_ok;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // element / term counters, column outer, row inner
    always_comb
    begin
        c_next     = c_reg;
        r_next     = r_reg;
        i_next     = i_reg;
        lim_next   = lim_reg;
        drain_next = drain_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    c_next   = '0;
                    r_next   = '0;
                    i_next   = '0;
                    lim_next = IDX_W'(act_dim - 3'd1);
                end
            end
            S_ISSUE:
            begin
                i_next = i_reg + 2'd1;
                if (last_term)
                begin
                    drain_next = PIPE_DRAIN;
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    i_next = '0;
                    if (last_row)
                    begin
                        r_next = '0;
                        c_next = c_reg + 2'd1;
                    end
                    else
                    begin
                        r_next = r_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                i_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            c_reg     <= '0;
            r_reg     <= '0;
            i_reg     <= '0;
            lim_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            r_reg     <= r_next;
            i_reg     <= i_next;
            lim_reg   <= lim_next;
            drain_reg <= drain_next;
        end
    end

endmodule

FILE: hw/rtl/smm_datapath.sv
`timescale 1ns / 1ps

module smm_datapath
    import smm_pkg::*;
#(
    parameter int unsigned MAX_DIM   = 4,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  smm_cmd_t                 cmd,
    output smm_stat_t                stat,
    input  logic signed [DATA_W-1:0] in_value,
    input  logic                     in_target,
    input  logic [IDX_W-1:0]         in_col,
    input  logic [IDX_W-1:0]         in_row,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] out_value,
    output logic [IDX_W-1:0]         out_col,
    output logic [IDX_W-1:0]         out_row,
    output logic                     out_sat,
    output logic                     out_last
);

    localparam int unsigned     CELLS = MAX_DIM * MAX_DIM;
    localparam int unsigned     AW    = $clog2(CELLS);
    localparam logic [AW-1:0]   DIM_A = AW'(MAX_DIM);
    localparam logic [IDX_W:0]  DIM_I = (IDX_W + 1)'(MAX_DIM);

    logic signed [DATA_W-1:0] left_mem  [CELLS];
    logic signed [DATA_W-1:0] right_mem [CELLS];

    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_left_addr;
    logic [AW-1:0]            rd_right_addr;
    logic                     wr_in_range;
    logic                     wr_left;
    logic                     wr_right;

    logic signed [DATA_W-1:0] a_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic                     v1_reg, f1_reg;
    logic signed [ACC_W-1:0]  prod_next, prod_reg;
    logic                     v2_reg, f2_reg;
    logic signed [ACC_W-1:0]  shifted;
    logic signed [ACC_W-1:0]  acc_next, acc_reg;

    logic                     ovf;
    logic signed [DATA_W-1:0] sat_value;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [IDX_W-1:0]         row_reg;
    logic                     sat_reg;
    logic                     last_reg;

    assign wr_addr       = AW'(in_col) * DIM_A + AW'(in_row);
    assign rd_left_addr  = AW'(cmd.term) * DIM_A + AW'(cmd.row);
    assign rd_right_addr = AW'(cmd.col) * DIM_A + AW'(cmd.term);
    assign wr_in_range   = ({1'b0, in_col} < DIM_I) && ({1'b0, in_row} < DIM_I);
    assign wr_left       = cmd.store && wr_in_range && !in_target;
    assign wr_right      = cmd.store && wr_in_range && in_target;

    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[wr_addr] <= in_value;
        end
        a_reg <= left_mem[rd_left_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_right)
        begin
            right_mem[wr_addr] <= in_value;
        end
        b_reg <= right_mem[rd_right_addr];
    end

    assign prod_next = a_reg * b_reg;
    // arithmetic shift gives the floor of the scaled product
    assign shifted   = prod_reg >>> FRAC_BITS;
    assign acc_next  = (f2_reg ? '0 : acc_reg) + shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (v2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            f1_reg <= cmd.mac_first;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
        end
    end

    // upper 33 bits must all agree to fit in 32
    assign ovf       = !((&acc_reg[ACC_W-1:DATA_W-1]) || !(|acc_reg[ACC_W-1:DATA_W-1]));
    assign sat_value = ovf ? (acc_reg[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc_reg[DATA_W-1:0];

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            value_reg <= sat_value;
            col_reg   <= cmd.col;
            row_reg   <= cmd.row;
            sat_reg   <= ovf;
            last_reg  <= cmd.last;
        end
    end

    assign stat.out_full = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = value_reg;
    assign out_col       = col_reg;
    assign out_row       = row_reg;
    assign out_sat       = sat_reg;
    assign out_last      = last_reg;

endmodule

FILE: hw/rtl/square_matrix_multiply_unit.sv
`timescale 1ns / 1ps
// Square matrix multiplier, 3x3 or 4x4, signed Q16.16.
// in_ch: each request writes one element of the left (target 0) or right
//   (target 1) matrix at column/row. A request with compute_now set stores its
//   element and then produces P = A * B, column-major, last element flagged.
// out_ch: n*n product elements per compute request; sums are saturated to 32 bits and
//   the saturated flag marks clipped elements.
// APB: register 0 (byte address 0) is dimension, reset 4; values below 3 act
//   as 3, above MAX_DIM as MAX_DIM. Write it only while the unit is idle.
// A load-only request is stored and the unit stays idle. A compute request runs
//   n*n elements through one multiply-accumulate unit: for each, n terms are
//   issued, the pipeline (read, multiply, accumulate) drains, and the element
//   is emitted.
// in_ch.ready is high only while no product run is in progress.
// A stalled receiver holds the output register; the run pauses at the emit
//   step until the slot frees. Reset idles the controller and sets dimension
//   to 4; matrix stores are undefined until written.
module square_matrix_multiply_unit
    import smm_pkg::*;
#(
    parameter int unsigned MAX_DIM   = 4,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    smm_in_if.sink            in_ch,
    smm_out_if.source         out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DIM_W-1:0] dimension_reg, dimension_next;
    logic             cfg_wr;
    logic             cfg_hit;
    smm_cmd_t         cmd;
    smm_stat_t        stat;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[APB_AW-1:2] == REG_DIMENSION);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? APB_DW'(dimension_reg) : '0;

    always_comb
    begin
        dimension_next = cfg_wr ? pwdata[DIM_W-1:0] : dimension_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_RESET;
        end
        else
        begin
            dimension_reg <= dimension_next;
        end
    end

    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .dimension  (dimension_reg),
        .in_valid   (in_ch.valid),
        .in_compute (in_ch.compute_now),
        .in_ready   (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    smm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_value  (in_ch.element_value),
        .in_target (in_ch.target_matrix),
        .in_col    (in_ch.column_index),
        .in_row    (in_ch.row_index),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_value (out_ch.product_value),
        .out_col   (out_ch.out_column),
        .out_row   (out_ch.out_row),
        .out_sat   (out_ch.saturated),
        .out_last  (out_ch.last_result)
    );

`include "square_matrix_multiply_unit_assert.svh"

    `SMM_ASSERT_NOW(a_no_issue_while_ready, clk, rst_n, in_ch.ready, !cmd.mac_issue && !cmd.emit, "mac issued while accepting requests")
    `SMM_ASSERT_NOW(a_emit_slot_free, clk, rst_n, cmd.emit, !out_ch.valid || out_ch.ready, "result emitted over an unaccepted one")
    `SMM_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.emit, out_ch.valid, "emitted result not presented")
    `SMM_ASSERT_NEXT(a_last_ends_run, clk, rst_n, cmd.emit && cmd.last, in_ch.ready, "run did not end after last element")

endmodule
